// File: sv/bba_pkg.sv
// Shared types and constants for the bitmap buddy allocator.
package bba_pkg;

   // Region geometry
   localparam int PAGES_PER_REGION = 128;
   localparam int LEVELS           = 4;
   localparam int PAGE_IDX_W       = $clog2(PAGES_PER_REGION);
   localparam int COUNT_W          = PAGE_IDX_W + 1;
   localparam int BLOCK_INDEX_W    = 7;
   localparam int SIZE_W           = 2;
   localparam int CMP_W            = (BLOCK_INDEX_W > COUNT_W) ? BLOCK_INDEX_W : COUNT_W;

   typedef logic [PAGES_PER_REGION-1:0] page_map_type;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   typedef struct packed {
      op_type                   operation;
      logic [SIZE_W-1:0]        size_class;
      logic [BLOCK_INDEX_W-1:0] block_index;
   } req_word_type;

   typedef struct packed {
      status_type               status;
      logic [BLOCK_INDEX_W-1:0] granted_index;
   } rsp_word_type;

endpackage

// File: sv/bitmap_buddy_allocator.sv
// Top level of the bitmap buddy allocator: request register, bitmap update, response register.
//
// Usage:
//   The req_ channel carries one word per request: allocate (lowest free
//   block of size_class) or free (block_index of size_class). The rsp_
//   channel returns exactly one word per request, in order: a status and,
//   for a successful allocate, the granted block index.
//   An accepted request is held in the request register; its response word
//   is then registered in the response register and offered on rsp_.
//   Throughput: one request per cycle unless rsp_ready stalls; the search
//   of the chosen bitmap, the clear/set of all four bitmaps and the
//   three-step merge all sit between the request register and the response
//   register, and the bitmaps are updated in the same cycle, so the next
//   request sees the new state.
//   Stall: while a response word waits on rsp_ready, the request register
//   holds its word and req_ready drops once that register is occupied.
//   Reset: synchronous, active high; all blocks of every size become free,
//   both pipeline registers empty. No clearing pass is needed.
module bitmap_buddy_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bba_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bba_pkg::rsp_word_type rsp_word
);
   import bba_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff, in_word_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   page_map_type free_ff [LEVELS];
   page_map_type free_in [LEVELS];

   logic         advance;
   logic         step;
   logic         found;
   logic         in_range;
   logic [PAGE_IDX_W-1:0] find_idx;
   logic [PAGE_IDX_W-1:0] target;
   logic [PAGE_IDX_W-1:0] page_base;
   logic [COUNT_W-1:0]    level_cnt;
   page_map_type          sel_map;
   rsp_word_type          result;

   // handshake: response register drains or is empty
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // lowest free block in the requested size class
   always_comb begin
      level_cnt = COUNT_W'(PAGES_PER_REGION >> in_word_ff.size_class);
      sel_map   = free_ff[in_word_ff.size_class];
      found     = 1'b0;
      find_idx  = '0;
      for (int j = PAGES_PER_REGION - 1; j >= 0; j--) begin
         if (sel_map[j]) begin
            found    = 1'b1;
            find_idx = PAGE_IDX_W'(j);
         end
      end
      in_range = CMP_W'(in_word_ff.block_index) < CMP_W'(level_cnt);
   end

   // bitmap update and status
   always_comb begin
      logic [PAGE_IDX_W-1:0] page_j;
      logic [PAGE_IDX_W-1:0] cur;
      logic                  cont;
      int                    lv;
      int                    m;
      lv = int'(in_word_ff.size_class);
      target = (in_word_ff.operation == OP_ALLOC) ? find_idx
                                                  : PAGE_IDX_W'(in_word_ff.block_index);
      page_base = PAGE_IDX_W'(target << lv);
      for (int s = 0; s < LEVELS; s++) begin
         free_in[s] = free_ff[s];
      end
      result.status        = STATUS_OK;
      result.granted_index = '0;

      case (in_word_ff.operation)
         OP_ALLOC: begin
            if (!found) begin
               result.status = STATUS_EXHAUSTED;
            end else begin
               result.granted_index = BLOCK_INDEX_W'(find_idx);
               // clear every block overlapping the chosen one, at all levels
               for (int s = 0; s < LEVELS; s++) begin
                  m = (s > lv) ? s : lv;
                  for (int j = 0; j < (PAGES_PER_REGION >> s); j++) begin
                     page_j = PAGE_IDX_W'(j << s);
                     if ((page_j >> m) == (page_base >> m)) begin
                        free_in[s][j] = 1'b0;
                     end
                  end
               end
            end
         end
         OP_FREE: begin
            if (!in_range) begin
               result.status = STATUS_RANGE;
            end else begin
               // set the block and everything inside it
               for (int s = 0; s < LEVELS; s++) begin
                  for (int j = 0; j < (PAGES_PER_REGION >> s); j++) begin
                     page_j = PAGE_IDX_W'(j << s);
                     if (s <= lv && (page_j >> lv) == (page_base >> lv)) begin
                        free_in[s][j] = 1'b1;
                     end
                  end
               end
               // merge upward while the buddy is free
               cur  = target;
               cont = 1'b1;
               for (int a = 0; a < LEVELS - 1; a++) begin
                  if (a >= lv && cont) begin
                     if (free_in[a][cur ^ PAGE_IDX_W'(1)]) begin
                        cur = cur >> 1;
                        free_in[a+1][cur] = 1'b1;
                     end else begin
                        cont = 1'b0;
                     end
                  end
               end
            end
         end
         default: begin
            result.status = STATUS_OK;
         end
      endcase
   end

   // pipeline register next values
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            rsp_word_in = result;
         end
      end
      if (req_ready) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_word_in = req_word;
         end
      end
   end

   // control and bitmap state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < LEVELS; s++) begin
            free_ff[s] <= {PAGES_PER_REGION{1'b1}}
                          >> (PAGES_PER_REGION - (PAGES_PER_REGION >> s));
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            for (int s = 0; s < LEVELS; s++) begin
               free_ff[s] <= free_in[s];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// File: sv/bba_checker.sv
// Port-level checker for the bitmap buddy allocator, bound to the top level.
module bba_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input bba_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input bba_pkg::rsp_word_type rsp_word
);
   import bba_pkg::*;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // failed requests never carry a granted index
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != STATUS_OK |-> rsp_word.granted_index == '0)
      else $error("nonzero granted index on failed request");

   // nothing comes out in the first cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a fresh response follows an accepted request, registered in the request register and then the response register
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

endmodule

bind bitmap_buddy_allocator bba_checker u_bba_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
